// ===== rtl/dmr_pkg.sv =====
// Package for the docking move/rotate controller: modes, states, command types,
// fixed-point constants and the CORDIC angle table. No dependencies.
`timescale 1ns / 1ps
package dmr_pkg;
   localparam int CordicIters = 16;
   localparam int IterW = $clog2(CordicIters + 1);
   localparam int AccW = 40;

   localparam logic signed [AccW-1:0] QPi = 40'sd205887;
   localparam logic signed [AccW-1:0] QHalfPi = 40'sd102944;
   localparam logic signed [AccW-1:0] QTwoPi = 40'sd411775;
   localparam logic signed [31:0] AbortVal = -32'sd65536;
   localparam logic [15:0] InvGain = 16'd39797;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_MOVE = 2'd1,
      MODE_ROTATE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      REQ_GOAL = 2'd0,
      REQ_POSE = 2'd1,
      REQ_TICK = 2'd2,
      REQ_NONE = 2'd3
   } req_type_type;

   typedef enum logic [2:0] {
      CFG_NORMAL_GAIN = 3'd0,
      CFG_SLOW_GAIN = 3'd1,
      CFG_ACCEL_STEP = 3'd2,
      CFG_POINT_TOL = 3'd3,
      CFG_ANGLE_TOL = 3'd4,
      CFG_TURN_GAIN = 3'd5,
      CFG_TURN_LIMIT = 3'd6,
      CFG_UNUSED = 3'd7
   } cfg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VEC_INIT,
      ST_VEC_ITER,
      ST_VEC_SCALE,
      ST_DIST_CHECK,
      ST_GAIN_MUL,
      ST_ROT_INIT,
      ST_ROT_ITER,
      ST_ROT_SCALE_X,
      ST_ROT_SCALE_Y,
      ST_RAMP,
      ST_TURN_MUL,
      ST_TURN_CLAMP,
      ST_OUTPUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic vec_init;
      logic vec_iter;
      logic vec_scale;
      logic dist_to_rotate;
      logic gain_mul;
      logic rot_init;
      logic rot_iter;
      logic rot_scale_x;
      logic rot_scale_y;
      logic ramp;
      logic turn_mul;
      logic turn_clamp;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic iter_done;
      logic near_point;
      logic near_angle;
   } dp_status_type;

   function automatic logic signed [AccW-1:0] atan_entry(input logic [IterW-1:0] i);
      logic signed [AccW-1:0] r;
      unique case (i)
         0: r = 40'sd51472;
         1: r = 40'sd30386;
         2: r = 40'sd16055;
         3: r = 40'sd8150;
         4: r = 40'sd4091;
         5: r = 40'sd2047;
         6: r = 40'sd1024;
         7: r = 40'sd512;
         8: r = 40'sd256;
         9: r = 40'sd128;
         10: r = 40'sd64;
         11: r = 40'sd32;
         12: r = 40'sd16;
         13: r = 40'sd8;
         14: r = 40'sd4;
         15: r = 40'sd2;
         16: r = 40'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage

// ===== rtl/dmr_ctrl.sv =====
// Controller state machine for the docking move/rotate controller.
// Depends on dmr_pkg for states, modes and the command/status structs.
`timescale 1ns / 1ps
module dmr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  dmr_pkg::mode_type      mode,
   input  dmr_pkg::dp_status_type status,
   input  logic                   out_free,
   output logic                   busy,
   output logic                   load_out,
   output dmr_pkg::dp_cmd_type    cmd
);
   dmr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dmr_pkg::ST_IDLE: begin
            if (start) begin
               if (mode == dmr_pkg::MODE_MOVE) state_in = dmr_pkg::ST_VEC_INIT;
               else if (mode == dmr_pkg::MODE_ROTATE) state_in = dmr_pkg::ST_TURN_MUL;
               else state_in = dmr_pkg::ST_OUTPUT;
            end
         end
         dmr_pkg::ST_VEC_INIT: state_in = dmr_pkg::ST_VEC_ITER;
         dmr_pkg::ST_VEC_ITER: begin
            if (status.iter_done) state_in = dmr_pkg::ST_VEC_SCALE;
         end
         dmr_pkg::ST_VEC_SCALE: state_in = dmr_pkg::ST_DIST_CHECK;
         dmr_pkg::ST_DIST_CHECK: begin
            state_in = status.near_point ? dmr_pkg::ST_OUTPUT : dmr_pkg::ST_GAIN_MUL;
         end
         dmr_pkg::ST_GAIN_MUL: state_in = dmr_pkg::ST_ROT_INIT;
         dmr_pkg::ST_ROT_INIT: state_in = dmr_pkg::ST_ROT_ITER;
         dmr_pkg::ST_ROT_ITER: begin
            if (status.iter_done) state_in = dmr_pkg::ST_ROT_SCALE_X;
         end
         dmr_pkg::ST_ROT_SCALE_X: state_in = dmr_pkg::ST_ROT_SCALE_Y;
         dmr_pkg::ST_ROT_SCALE_Y: state_in = dmr_pkg::ST_RAMP;
         dmr_pkg::ST_RAMP: state_in = dmr_pkg::ST_OUTPUT;
         dmr_pkg::ST_TURN_MUL: state_in = dmr_pkg::ST_TURN_CLAMP;
         dmr_pkg::ST_TURN_CLAMP: state_in = dmr_pkg::ST_OUTPUT;
         dmr_pkg::ST_OUTPUT: begin
            if (out_free) state_in = dmr_pkg::ST_IDLE;
         end
         default: state_in = dmr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = (state_ff != dmr_pkg::ST_IDLE);
      load_out = 1'b0;
      unique case (state_ff)
         dmr_pkg::ST_VEC_INIT: cmd.vec_init = 1'b1;
         dmr_pkg::ST_VEC_ITER: cmd.vec_iter = 1'b1;
         dmr_pkg::ST_VEC_SCALE: cmd.vec_scale = 1'b1;
         dmr_pkg::ST_DIST_CHECK: cmd.dist_to_rotate = status.near_point;
         dmr_pkg::ST_GAIN_MUL: cmd.gain_mul = 1'b1;
         dmr_pkg::ST_ROT_INIT: cmd.rot_init = 1'b1;
         dmr_pkg::ST_ROT_ITER: cmd.rot_iter = 1'b1;
         dmr_pkg::ST_ROT_SCALE_X: cmd.rot_scale_x = 1'b1;
         dmr_pkg::ST_ROT_SCALE_Y: cmd.rot_scale_y = 1'b1;
         dmr_pkg::ST_RAMP: cmd.ramp = 1'b1;
         dmr_pkg::ST_TURN_MUL: cmd.turn_mul = 1'b1;
         dmr_pkg::ST_TURN_CLAMP: cmd.turn_clamp = 1'b1;
         dmr_pkg::ST_OUTPUT: load_out = out_free;
         default: ;
      endcase
   end
endmodule

// ===== rtl/dmr_datapath.sv =====
// Datapath of the docking move/rotate controller: stored goal, pose and velocity,
// the shared iterative CORDIC, gain multiplies, ramps and the heading P control.
// Depends on dmr_pkg.
`timescale 1ns / 1ps
module dmr_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_fire,
   input  logic [1:0]             req_kind,
   input  logic signed [31:0]     req_pos_x,
   input  logic signed [31:0]     req_pos_y,
   input  logic signed [18:0]     req_heading,
   input  logic                   req_slow,
   input  logic [23:0]            normal_gain,
   input  logic [23:0]            slow_gain,
   input  logic [15:0]            accel_step,
   input  logic [15:0]            point_tolerance,
   input  logic [15:0]            angle_tolerance,
   input  logic [23:0]            turn_gain,
   input  logic [19:0]            turn_limit,
   input  dmr_pkg::dp_cmd_type    cmd,
   output dmr_pkg::dp_status_type status,
   output dmr_pkg::mode_type      mode,
   output logic                   have_goal,
   output logic signed [31:0]     vel_x,
   output logic signed [31:0]     vel_y,
   output logic signed [31:0]     vel_turn
);
   localparam int W = dmr_pkg::AccW;

   logic signed [31:0] goal_x_ff, goal_y_ff, pose_x_ff, pose_y_ff;
   logic signed [18:0] goal_yaw_ff, pose_yaw_ff;
   logic slow_ff, have_goal_ff;
   dmr_pkg::mode_type mode_ff;
   logic signed [31:0] vx_ff, vy_ff, vt_ff;

   logic signed [W-1:0] cx_ff, cy_ff, cz_ff, tx_ff, ty_ff;
   logic [dmr_pkg::IterW-1:0] it_ff;
   logic zero_ff, neg_ff;
   logic signed [W-1:0] dist_ff, s_ff;
   logic signed [63:0] p_ff;

   logic goal_req, abort_req;
   assign goal_req = req_fire && (req_kind == dmr_pkg::REQ_GOAL);
   assign abort_req = goal_req && (req_pos_x == dmr_pkg::AbortVal)
                      && (req_pos_y == dmr_pkg::AbortVal);

   // CORDIC step.
   logic signed [W-1:0] atan_v, sx, sy;
   logic signed [W-1:0] nx, ny, nz;
   logic vec_dir;
   assign atan_v = dmr_pkg::atan_entry(it_ff);
   assign sx = cx_ff >>> it_ff;
   assign sy = cy_ff >>> it_ff;
   assign vec_dir = cmd.vec_iter ? (cy_ff >= 0) : (cz_ff < 0);
   always_comb begin
      if (vec_dir) begin
         nx = cx_ff + sy;
         ny = cy_ff - sx;
         nz = cz_ff + atan_v;
      end else begin
         nx = cx_ff - sy;
         ny = cy_ff + sx;
         nz = cz_ff - atan_v;
      end
   end

   // Unscale multiplier shared by vectoring and rotation outputs.
   logic signed [W-1:0] us_src;
   logic signed [W+17:0] us_prod;
   logic signed [W-1:0] us_res;
   assign us_src = cmd.rot_scale_y ? cy_ff : cx_ff;
   assign us_prod = us_src * $signed({1'b0, dmr_pkg::InvGain}) + (W+18)'(32768);
   assign us_res = W'(us_prod >>> 16);

   // Vectoring input offset and rotation angle wrap.
   logic signed [W-1:0] dx, dy, th0, th1;
   logic th_neg;
   assign dx = W'(goal_x_ff) - W'(pose_x_ff);
   assign dy = W'(goal_y_ff) - W'(pose_y_ff);
   always_comb begin
      th0 = cz_ff - W'(pose_yaw_ff);
      if (th0 > dmr_pkg::QPi) th0 = th0 - dmr_pkg::QTwoPi;
      else if (th0 < -dmr_pkg::QPi) th0 = th0 + dmr_pkg::QTwoPi;
      th_neg = 1'b0;
      th1 = th0;
      if (th0 > dmr_pkg::QHalfPi) begin
         th1 = th0 - dmr_pkg::QPi;
         th_neg = 1'b1;
      end else if (th0 < -dmr_pkg::QHalfPi) begin
         th1 = th0 + dmr_pkg::QPi;
         th_neg = 1'b1;
      end
   end

   // Gain multiply.
   logic [23:0] gain;
   logic signed [63:0] gprod, gs;
   assign gain = slow_ff ? slow_gain : normal_gain;
   assign gprod = 64'(dist_ff) * $signed({40'd0, gain});
   assign gs = gprod >>> 16;

   // Ramp.
   function automatic logic signed [31:0] ramp_f(input logic signed [31:0] v,
                                                 input logic signed [W-1:0] t,
                                                 input logic [15:0] a);
      logic signed [W-1:0] r;
      if (t >= 0) begin
         r = W'(v) + W'(a);
         if (r >= t) r = t;
      end else begin
         r = W'(v) - W'(a);
         if (r <= t) r = t;
      end
      return r[31:0];
   endfunction

   // Heading control.
   logic signed [19:0] diff, ad;
   logic signed [W-1:0] p_sh, lim, vt;
   assign diff = 20'(goal_yaw_ff) - 20'(pose_yaw_ff);
   assign ad = diff[19] ? -diff : diff;
   assign p_sh = W'(p_ff >>> 16);
   assign lim = W'(turn_limit);
   always_comb begin
      if ((pose_yaw_ff >= 0) == (goal_yaw_ff >= 0)) begin
         if (diff >= 0) vt = (p_sh < lim) ? p_sh : lim;
         else vt = (p_sh > -lim) ? p_sh : -lim;
      end else if (pose_yaw_ff < 0) begin
         if (W'(goal_yaw_ff) - W'(pose_yaw_ff) >= dmr_pkg::QPi)
            vt = (-p_sh > -lim) ? -p_sh : -lim;
         else vt = (p_sh < lim) ? p_sh : lim;
      end else begin
         if (W'(pose_yaw_ff) - W'(goal_yaw_ff) <= dmr_pkg::QPi)
            vt = (p_sh > -lim) ? p_sh : -lim;
         else vt = (-p_sh < lim) ? -p_sh : lim;
      end
   end

   assign status.iter_done = (it_ff == dmr_pkg::IterW'(dmr_pkg::CordicIters - 1));
   assign status.near_point = (dist_ff <= W'(point_tolerance));
   assign status.near_angle = (ad < 20'(angle_tolerance));

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff <= '0; goal_y_ff <= '0; goal_yaw_ff <= '0;
         pose_x_ff <= '0; pose_y_ff <= '0; pose_yaw_ff <= '0;
         vx_ff <= '0; vy_ff <= '0; vt_ff <= '0;
         mode_ff <= dmr_pkg::MODE_IDLE;
         have_goal_ff <= 1'b0;
         slow_ff <= 1'b0;
      end else begin
         if (goal_req) begin
            vx_ff <= '0; vy_ff <= '0; vt_ff <= '0;
            if (abort_req) begin
               mode_ff <= dmr_pkg::MODE_IDLE;
            end else begin
               goal_x_ff <= req_pos_x; goal_y_ff <= req_pos_y;
               goal_yaw_ff <= req_heading;
               slow_ff <= req_slow;
               mode_ff <= dmr_pkg::MODE_MOVE;
               have_goal_ff <= 1'b1;
            end
         end
         if (req_fire && (req_kind == dmr_pkg::REQ_POSE)) begin
            pose_x_ff <= req_pos_x; pose_y_ff <= req_pos_y;
            pose_yaw_ff <= req_heading;
         end
         if (cmd.dist_to_rotate) begin
            vx_ff <= '0; vy_ff <= '0; vt_ff <= '0;
            mode_ff <= dmr_pkg::MODE_ROTATE;
         end
         if (cmd.ramp) begin
            vx_ff <= ramp_f(vx_ff, tx_ff, accel_step);
            vy_ff <= ramp_f(vy_ff, ty_ff, accel_step);
            vt_ff <= '0;
         end
         if (cmd.turn_mul) begin
            vx_ff <= '0; vy_ff <= '0;
            if (status.near_angle) begin
               vt_ff <= '0;
               mode_ff <= dmr_pkg::MODE_IDLE;
            end
         end
         if (cmd.turn_clamp && (mode_ff == dmr_pkg::MODE_ROTATE)) begin
            vt_ff <= vt[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.vec_init) begin
         it_ff <= '0;
         zero_ff <= (dx == 0) && (dy == 0);
         if (dx < 0) begin
            cx_ff <= -dx; cy_ff <= -dy;
            cz_ff <= (dy >= 0) ? dmr_pkg::QPi : -dmr_pkg::QPi;
         end else begin
            cx_ff <= dx; cy_ff <= dy; cz_ff <= '0;
         end
      end
      if (cmd.vec_iter || cmd.rot_iter) begin
         cx_ff <= nx; cy_ff <= ny; cz_ff <= nz;
         it_ff <= it_ff + dmr_pkg::IterW'(1);
      end
      if (cmd.vec_scale) begin
         dist_ff <= zero_ff ? '0 : us_res;
         if (zero_ff) cz_ff <= '0;
      end
      if (cmd.gain_mul) begin
         s_ff <= (gs > $signed({40'd0, normal_gain})) ? W'(normal_gain) : W'(gs);
      end
      if (cmd.rot_init) begin
         cx_ff <= s_ff; cy_ff <= '0; cz_ff <= th1;
         neg_ff <= th_neg;
         it_ff <= '0;
      end
      if (cmd.rot_scale_x) tx_ff <= neg_ff ? -us_res : us_res;
      if (cmd.rot_scale_y) ty_ff <= neg_ff ? -us_res : us_res;
      if (cmd.turn_mul) p_ff <= 64'(diff) * $signed({40'd0, turn_gain});
   end

   assign mode = mode_ff;
   assign have_goal = have_goal_ff;
   assign vel_x = vx_ff;
   assign vel_y = vy_ff;
   assign vel_turn = vt_ff;
endmodule

// ===== rtl/dock_move_rotate_controller.sv =====
// Top level of the docking move/rotate controller: configuration registers,
// stream ports, output register. Depends on dmr_pkg, dmr_ctrl and dmr_datapath.
//
//  channel | dir | tdata fields (low bit up)                  | tuser
//  req     | in  | pos_x[31:0] pos_y[63:32] heading[82:64]     | req_type[1:0] slow[2]
//  rsp     | out | vel_x[31:0] vel_y[63:32] vel_turn[95:64]    | motion_mode[1:0]
//  csr     | in  | index, 24-bit data, write enable            | -
//
// A tick in MOVE makes two passes of 16 iterations through the single shared CORDIC
// unit, or stops after the distance check when the goal point is reached; a tick in
// ROTATE runs the turn multiply and clamp, one in IDLE goes straight to output, and goal
// and pose transactions start no tick. Reset is synchronous and clears the mode, stored
// goal, pose and velocity. A result waits in the output register while rsp_tready
// is low; the next transaction is accepted only after the pending tick has finished.
`timescale 1ns / 1ps
module dock_move_rotate_controller (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,  // pos_x, pos_y, heading, zero fill
   input  logic [2:0]   req_tuser,  // req_type, slow_mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // vel_x, vel_y, vel_turn
   output logic [1:0]   rsp_tuser,  // motion_mode
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_wdata
);
   logic [23:0] normal_gain_ff, slow_gain_ff, turn_gain_ff;
   logic [15:0] accel_ff, ptol_ff, atol_ff;
   logic [19:0] tlim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_gain_ff <= 24'd131072;
         slow_gain_ff <= 24'd229376;
         accel_ff <= 16'd197;
         ptol_ff <= 16'd328;
         atol_ff <= 16'd655;
         turn_gain_ff <= 24'd163840;
         tlim_ff <= 20'd65536;
      end else if (csr_we) begin
         unique case (dmr_pkg::cfg_index_type'(csr_index))
            dmr_pkg::CFG_NORMAL_GAIN: normal_gain_ff <= csr_wdata;
            dmr_pkg::CFG_SLOW_GAIN: slow_gain_ff <= csr_wdata;
            dmr_pkg::CFG_ACCEL_STEP: accel_ff <= csr_wdata[15:0];
            dmr_pkg::CFG_POINT_TOL: ptol_ff <= csr_wdata[15:0];
            dmr_pkg::CFG_ANGLE_TOL: atol_ff <= csr_wdata[15:0];
            dmr_pkg::CFG_TURN_GAIN: turn_gain_ff <= csr_wdata;
            dmr_pkg::CFG_TURN_LIMIT: tlim_ff <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   logic busy, load_out, req_fire, start, have_goal, out_free;
   dmr_pkg::dp_cmd_type cmd;
   dmr_pkg::dp_status_type status;
   dmr_pkg::mode_type mode;
   logic signed [31:0] vx, vy, vt;
   logic rsp_valid_ff;
   logic [95:0] rsp_data_ff;
   logic [1:0] rsp_user_ff;

   assign req_tready = !busy;
   assign req_fire = req_tvalid && req_tready;
   assign start = req_fire && (req_tuser[1:0] == dmr_pkg::REQ_TICK) && have_goal;
   assign out_free = !rsp_valid_ff || rsp_tready;

   dmr_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .mode(mode), .status(status),
      .out_free(out_free), .busy(busy), .load_out(load_out), .cmd(cmd)
   );

   dmr_datapath u_dp (
      .clock(clock), .reset(reset), .req_fire(req_fire), .req_kind(req_tuser[1:0]),
      .req_pos_x(req_tdata[31:0]), .req_pos_y(req_tdata[63:32]),
      .req_heading(req_tdata[82:64]), .req_slow(req_tuser[2]),
      .normal_gain(normal_gain_ff), .slow_gain(slow_gain_ff), .accel_step(accel_ff),
      .point_tolerance(ptol_ff), .angle_tolerance(atol_ff), .turn_gain(turn_gain_ff),
      .turn_limit(tlim_ff), .cmd(cmd), .status(status), .mode(mode),
      .have_goal(have_goal), .vel_x(vx), .vel_y(vy), .vel_turn(vt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= {vt, vy, vx};
         rsp_user_ff <= mode;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready)
      else $error("transaction accepted while a tick is in progress");
   a_load_needs_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> out_free)
      else $error("result loaded over an unread result");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |=> busy)
      else $error("tick did not start the controller");
endmodule
